[rtl/assert_macros.svh]
// Assertion macros shared by the timer queue RTL.
// No dependencies; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define STQ_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// Check that a trigger implies a condition in the following clock cycle.
`define STQ_ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("assertion failed");

`endif

[rtl/stq_pkg.sv]
// Shared types and constants for the sorted timer queue.
// No dependencies.
package stq_pkg;
   localparam int unsigned CAPACITY = 16;
   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
   localparam int unsigned ID_W = 31;
   localparam int unsigned TIME_W = 31;
   localparam int unsigned DL_W = 32;
   localparam int unsigned DELAY_W = 24;
   localparam int unsigned TAG_W = 32;
   localparam int unsigned MARGIN_W = 16;
   localparam int unsigned FIRED_W = 5;
   localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};
   localparam logic [ID_W-1:0] ID_FIRST = ID_W'(1);

   localparam logic [1:0] OP_SET = 2'd0;
   localparam logic [1:0] OP_KILL = 2'd1;
   localparam logic [1:0] OP_CHECK = 2'd2;

   localparam logic [1:0] KIND_SET = 2'd0;
   localparam logic [1:0] KIND_KILL = 2'd1;
   localparam logic [1:0] KIND_EXPIRY = 2'd2;
   localparam logic [1:0] KIND_DONE = 2'd3;

   localparam logic CSR_LATE_MARGIN = 1'b0;
   localparam logic CSR_BURST_LIMIT = 1'b1;

   typedef struct packed {
      logic              valid;
      logic [ID_W-1:0]   id;
      logic [DL_W-1:0]   deadline;
      logic [TAG_W-1:0]  tag;
      logic              notify;
   } entry_type;

   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_INSERT,
      CMD_KILL,
      CMD_POP
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type       op;
      logic [ID_W-1:0]  kill_id;
      entry_type        fresh;
   } cell_cmd_type;
endpackage

[rtl/stq_if.sv]
// Channel interfaces of the sorted timer queue: request, response, register write.
// Depends on stq_pkg.
interface stq_req_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   op;
   logic [stq_pkg::TIME_W-1:0]   now;
   logic [stq_pkg::DELAY_W-1:0]  delay_ms;
   logic [stq_pkg::ID_W-1:0]     kill_id;
   logic [stq_pkg::TAG_W-1:0]    tag;
   logic                         notify;
   modport source (output valid, op, now, delay_ms, kill_id, tag, notify, input ready);
   modport sink (input valid, op, now, delay_ms, kill_id, tag, notify, output ready);
endinterface

interface stq_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   kind;
   logic [stq_pkg::ID_W-1:0]     result_id;
   logic [stq_pkg::TAG_W-1:0]    result_tag;
   logic [stq_pkg::FIRED_W-1:0]  fired_count;
   logic                         last;
   modport source (output valid, kind, result_id, result_tag, fired_count, last, input ready);
   modport sink (input valid, kind, result_id, result_tag, fired_count, last, output ready);
endinterface

interface stq_csr_if;
   logic                          valid;
   logic                          ready;
   logic                          index;
   logic [stq_pkg::MARGIN_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[rtl/stq_cell.sv]
// One slot of the sorted timer chain: holds a timer, inserts, removes, shifts.
// Depends on stq_pkg.
module stq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  stq_pkg::cell_cmd_type cmd,
   input  stq_pkg::entry_type    left_entry,
   input  stq_pkg::entry_type    right_entry,
   input  logic                  left_ge,
   input  logic                  left_hit,
   output stq_pkg::entry_type    entry,
   output logic                  ge,
   output logic                  hit
);
   import stq_pkg::*;

   entry_type entry_ff, entry_in;

   assign ge = entry_ff.valid && (cmd.fresh.deadline >= entry_ff.deadline);
   assign hit = left_hit || (entry_ff.valid && (entry_ff.id == cmd.kill_id));
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         CMD_INSERT: begin
            if (!ge) begin
               entry_in = left_ge ? cmd.fresh : left_entry;
            end
         end
         CMD_KILL: begin
            if (hit) begin
               entry_in = right_entry;
            end
         end
         CMD_POP: entry_in = right_entry;
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end
endmodule

[rtl/sorted_timer_queue.sv]
// Sorted timer queue: a chain of CAPACITY cells kept in deadline order.
// Set and kill responses are registered and appear in the cycle after accept;
// check pops each expired timer at the chain head, then gives a done response.
// A new request is taken once the previous one has finished and the response
// register is free. Synchronous reset empties the chain, sets next id to 1,
// late margin to 100 and burst limit to 2.
module sorted_timer_queue (
   input logic    clock,
   input logic    reset,
   stq_req_if.sink   req_bus,
   stq_rsp_if.source rsp_bus,
   stq_csr_if.sink   csr_bus
);
   import stq_pkg::*;
   `include "assert_macros.svh"

   typedef enum logic {ST_IDLE, ST_CHECK} state_type;

   state_type               state_ff;
   logic [CNT_W-1:0]        count_ff;
   logic [ID_W-1:0]         next_id_ff;
   logic [MARGIN_W-1:0]     margin_ff;
   logic [FIRED_W-1:0]      burst_ff;
   logic [FIRED_W-1:0]      fired_ff;
   logic [TIME_W-1:0]       now_ff;
   logic                    rsp_valid_ff;
   logic [1:0]              kind_ff;
   logic [ID_W-1:0]         id_ff;
   logic [TAG_W-1:0]        tag_ff;
   logic [FIRED_W-1:0]      fired_out_ff;
   logic                    last_ff;

   cell_cmd_type            cmd;
   entry_type               cell_entry [CAPACITY];
   logic [CAPACITY-1:0]     cell_ge;
   logic [CAPACITY-1:0]     cell_hit;
   logic [CAPACITY-1:0]     cell_valid;
   logic                    out_free, accept, full, go;
   logic                    rsp_load;
   logic [DL_W:0]           late_dl;
   entry_type               empty_entry;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE) && out_free;
   assign accept = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign full = (count_ff == CNT_W'(CAPACITY));

   assign late_dl = {1'b0, cell_entry[0].deadline} + (DL_W + 1)'(margin_ff);
   always_comb begin
      if (fired_ff < burst_ff) begin
         go = cell_entry[0].valid && ({1'b0, now_ff} >= cell_entry[0].deadline);
      end else begin
         go = cell_entry[0].valid && ((DL_W + 1)'(now_ff) >= late_dl);
      end
   end

   always_comb begin
      rsp_load = 1'b0;
      if (accept && (req_bus.op == OP_SET || req_bus.op == OP_KILL)) begin
         rsp_load = 1'b1;
      end else if (state_ff == ST_CHECK && out_free) begin
         rsp_load = go ? cell_entry[0].notify : 1'b1;
      end
   end

   always_comb begin
      empty_entry = '0;
      cmd.op = CMD_NONE;
      cmd.kill_id = req_bus.kill_id;
      cmd.fresh.valid = 1'b1;
      cmd.fresh.id = next_id_ff;
      cmd.fresh.deadline = DL_W'(req_bus.now) + DL_W'(req_bus.delay_ms);
      cmd.fresh.tag = req_bus.tag;
      cmd.fresh.notify = req_bus.notify;
      if (accept && req_bus.op == OP_SET && !full) begin
         cmd.op = CMD_INSERT;
      end else if (accept && req_bus.op == OP_KILL) begin
         cmd.op = CMD_KILL;
      end else if (state_ff == ST_CHECK && out_free && go) begin
         cmd.op = CMD_POP;
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      stq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_entry  ((i == 0) ? empty_entry : cell_entry[(i == 0) ? 0 : i - 1]),
         .right_entry ((i == CAPACITY - 1) ? empty_entry
                                           : cell_entry[(i == CAPACITY - 1) ? i : i + 1]),
         .left_ge     ((i == 0) ? 1'b1 : cell_ge[(i == 0) ? 0 : i - 1]),
         .left_hit    ((i == 0) ? 1'b0 : cell_hit[(i == 0) ? 0 : i - 1]),
         .entry       (cell_entry[i]),
         .ge          (cell_ge[i]),
         .hit         (cell_hit[i])
      );
      assign cell_valid[i] = cell_entry[i].valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         next_id_ff <= ID_FIRST;
         margin_ff <= MARGIN_W'(100);
         burst_ff <= FIRED_W'(2);
         fired_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            if (csr_bus.index == CSR_LATE_MARGIN) begin
               margin_ff <= csr_bus.data;
            end else begin
               burst_ff <= csr_bus.data[FIRED_W-1:0];
            end
         end
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && !rsp_bus.ready);
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  now_ff <= req_bus.now;
                  fired_ff <= '0;
                  tag_ff <= '0;
                  fired_out_ff <= '0;
                  last_ff <= 1'b1;
                  if (req_bus.op == OP_SET) begin
                     kind_ff <= KIND_SET;
                     id_ff <= full ? '0 : next_id_ff;
                     if (!full) begin
                        count_ff <= count_ff + CNT_W'(1);
                        next_id_ff <= (next_id_ff == ID_MAX) ? ID_FIRST
                                                             : next_id_ff + ID_W'(1);
                     end
                  end else if (req_bus.op == OP_KILL) begin
                     kind_ff <= KIND_KILL;
                     id_ff <= cell_hit[CAPACITY-1] ? req_bus.kill_id : '0;
                     if (cell_hit[CAPACITY-1]) begin
                        count_ff <= count_ff - CNT_W'(1);
                     end
                  end else if (req_bus.op == OP_CHECK) begin
                     state_ff <= ST_CHECK;
                  end
               end
            end
            ST_CHECK: begin
               if (out_free) begin
                  if (go) begin
                     count_ff <= count_ff - CNT_W'(1);
                     if (fired_ff != {FIRED_W{1'b1}}) begin
                        fired_ff <= fired_ff + FIRED_W'(1);
                     end
                     if (cell_entry[0].notify) begin
                        kind_ff <= KIND_EXPIRY;
                        id_ff <= cell_entry[0].id;
                        tag_ff <= cell_entry[0].tag;
                        fired_out_ff <= '0;
                        last_ff <= 1'b0;
                     end
                  end else begin
                     kind_ff <= KIND_DONE;
                     id_ff <= '0;
                     tag_ff <= '0;
                     fired_out_ff <= fired_ff;
                     last_ff <= 1'b1;
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.kind = kind_ff;
   assign rsp_bus.result_id = id_ff;
   assign rsp_bus.result_tag = tag_ff;
   assign rsp_bus.fired_count = fired_out_ff;
   assign rsp_bus.last = last_ff;

   `STQ_ASSERT_ALWAYS(a_count_matches_cells, clock, reset,
      $countones(cell_valid) == int'(count_ff))
   `STQ_ASSERT_ALWAYS(a_count_in_range, clock, reset, count_ff <= CNT_W'(CAPACITY))
   `STQ_ASSERT_NEXT(a_pop_shrinks, clock, reset, cmd.op == CMD_POP,
      count_ff == $past(count_ff) - CNT_W'(1))
endmodule
